/* sv/rri_pkg.sv */
package rri_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TEX_BITS  = 16;
  localparam int W         = 32;
  localparam int NUM_W     = W + 1;
  localparam int DIV_N     = NUM_W + FRAC_BITS;
  localparam int PW        = 2 * W + 1;
  localparam int TEX_W     = TEX_BITS + 1;
  localparam int IN_W      = 8 * W;
  localparam int OUT_RAW_W = 4 * W + 2 * TEX_W + 1;
  localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [1:0] AXIS_XY = 2'd0;
  localparam logic [1:0] AXIS_YZ = 2'd1;
  localparam logic [1:0] AXIS_XZ = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_AXIS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_U_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_U_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_V_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_V_HIGH = 3'd5;

  typedef struct packed {
    logic [1:0]   axis;
    logic [W-1:0] offset;
    logic [W-1:0] u_low;
    logic [W-1:0] u_high;
    logic [W-1:0] v_low;
    logic [W-1:0] v_high;
  } cfg_t;

  typedef struct packed {
    logic [W-1:0] ox;
    logic [W-1:0] oy;
    logic [W-1:0] oz;
    logic [W-1:0] dx;
    logic [W-1:0] dy;
    logic [W-1:0] dz;
    logic [W-1:0] tmin;
    logic [W-1:0] tmax;
    logic         ok;
    logic         neg;
    logic         ff;
  } ray_t;

  typedef struct packed {
    logic         hit;
    logic [W-1:0] t;
    logic [W-1:0] px;
    logic [W-1:0] py;
    logic [W-1:0] pz;
    logic         ff;
  } res_t;

endpackage

/* sv/rri_tdiv.sv */
module rri_tdiv (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  rri_pkg::ray_t          in_ray,
  input  rri_pkg::cfg_t          cfg,
  output logic                   out_valid,
  output logic [rri_pkg::DIV_N-1:0] out_q,
  output rri_pkg::ray_t          out_ray
);

  localparam int N = rri_pkg::DIV_N;
  localparam int W = rri_pkg::W;

  // prep: pick normal axis, form |num| << FRAC and |dir_n|
  logic [W-1:0]     org_n, dir_n;
  logic             axis_ok;
  logic [W:0]       num, num_mag;
  logic [W-1:0]     dmag;
  rri_pkg::ray_t    prep_ray;

  always_comb begin
    axis_ok = 1'b1;
    org_n   = in_ray.oz;
    dir_n   = in_ray.dz;
    unique case (cfg.axis)
      rri_pkg::AXIS_XY: begin org_n = in_ray.oz; dir_n = in_ray.dz; end
      rri_pkg::AXIS_YZ: begin org_n = in_ray.ox; dir_n = in_ray.dx; end
      rri_pkg::AXIS_XZ: begin org_n = in_ray.oy; dir_n = in_ray.dy; end
      default:          axis_ok = 1'b0;
    endcase
    num      = {cfg.offset[W-1], cfg.offset} - {org_n[W-1], org_n};
    num_mag  = num[W] ? (~num + 1'b1) : num;
    dmag     = dir_n[W-1] ? (~dir_n + 1'b1) : dir_n;
    prep_ray     = in_ray;
    prep_ray.ok  = axis_ok && (dir_n != '0);
    prep_ray.neg = num[W] ^ dir_n[W-1];
    prep_ray.ff  = dir_n[W-1];
  end

  logic                prep_v_r;
  logic [N-1:0]        prep_dvd_r;
  logic [W-1:0]        prep_dm_r;
  rri_pkg::ray_t       prep_ray_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_v_r <= 1'b0;
    end else if (en) begin
      prep_v_r <= in_valid;
    end
    if (en) begin
      prep_dvd_r <= {num_mag, {rri_pkg::FRAC_BITS{1'b0}}};
      prep_dm_r  <= dmag;
      prep_ray_r <= prep_ray;
    end
  end

  // one quotient bit per stage; dividend shifts out as quotient shifts in
  logic                v_r   [N];
  logic [W:0]          rem_r [N];
  logic [N-1:0]        dq_r  [N];
  logic [W-1:0]        dm_r  [N];
  rri_pkg::ray_t       ray_r [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic          s_v;
    logic [W:0]    s_rem, sh, rem_nxt;
    logic [N-1:0]  s_dq;
    logic [W-1:0]  s_dm;
    rri_pkg::ray_t s_ray;
    logic          ge;

    if (k == 0) begin : g_first
      assign s_v   = prep_v_r;
      assign s_rem = '0;
      assign s_dq  = prep_dvd_r;
      assign s_dm  = prep_dm_r;
      assign s_ray = prep_ray_r;
    end else begin : g_next
      assign s_v   = v_r[k-1];
      assign s_rem = rem_r[k-1];
      assign s_dq  = dq_r[k-1];
      assign s_dm  = dm_r[k-1];
      assign s_ray = ray_r[k-1];
    end

    always_comb begin
      sh      = {s_rem[W-1:0], s_dq[N-1]};
      ge      = sh >= {1'b0, s_dm};
      rem_nxt = ge ? (sh - {1'b0, s_dm}) : sh;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= s_v;
      end
      if (en) begin
        rem_r[k] <= rem_nxt;
        dq_r[k]  <= {s_dq[N-2:0], ge};
        dm_r[k]  <= s_dm;
        ray_r[k] <= s_ray;
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign out_q     = dq_r[N-1];
  assign out_ray   = ray_r[N-1];

endmodule

/* sv/rri_point.sv */
module rri_point (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [rri_pkg::DIV_N-1:0] in_q,
  input  rri_pkg::ray_t             in_ray,
  input  rri_pkg::cfg_t             cfg,
  output logic                      out_valid,
  output rri_pkg::res_t             out_res,
  output logic [rri_pkg::W-1:0]     out_a_u,
  output logic [rri_pkg::W-1:0]     out_s_u,
  output logic [rri_pkg::W-1:0]     out_a_v,
  output logic [rri_pkg::W-1:0]     out_s_v
);

  localparam int N  = rri_pkg::DIV_N;
  localparam int W  = rri_pkg::W;
  localparam int PW = rri_pkg::PW;

  // P1: sign, range check, window
  logic         in_rng, hit1;
  logic [W-1:0] tq, t1;

  always_comb begin
    in_rng = (in_q[N-1:W-1] == '0) ||
             (in_ray.neg && (in_q == {{(N-W){1'b0}}, 1'b1, {(W-1){1'b0}}}));
    tq     = in_q[W-1:0];
    t1     = in_ray.neg ? (~tq + 1'b1) : tq;
    hit1   = in_ray.ok && in_rng &&
             ($signed(t1) > $signed(in_ray.tmin)) && ($signed(t1) < $signed(in_ray.tmax));
  end

  logic          p1_v_r, p1_hit_r;
  logic [W-1:0]  p1_t_r;
  rri_pkg::ray_t p1_ray_r;

  // P2: dir * t
  logic          p2_v_r, p2_hit_r;
  logic [W-1:0]  p2_t_r;
  rri_pkg::ray_t p2_ray_r;
  logic [2*W-1:0] p2_px_r, p2_py_r, p2_pz_r;

  // P3: point and bounds
  logic [PW-1:0] ptx, pty, ptz, pu, pv;
  logic          hit3;

  function automatic logic [PW-1:0] add_pt(input logic [W-1:0] o, input logic [2*W-1:0] p);
    logic [2*W-1:0] sh;
    sh = $signed(p) >>> rri_pkg::FRAC_BITS;
    return {{(PW-W){o[W-1]}}, o} + {{(PW-2*W){sh[2*W-1]}}, sh};
  endfunction

  function automatic logic [W-1:0] sat(input logic [PW-1:0] x);
    if (x[PW-1:W-1] == '0 || x[PW-1:W-1] == '1) return x[W-1:0];
    return x[PW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  endfunction

  function automatic logic [PW-1:0] sx(input logic [W-1:0] x);
    return {{(PW-W){x[W-1]}}, x};
  endfunction

  always_comb begin
    ptx = add_pt(p2_ray_r.ox, p2_px_r);
    pty = add_pt(p2_ray_r.oy, p2_py_r);
    ptz = add_pt(p2_ray_r.oz, p2_pz_r);
    pu  = (cfg.axis == rri_pkg::AXIS_YZ) ? ptz : ptx;
    pv  = (cfg.axis == rri_pkg::AXIS_XZ) ? ptz : pty;
    hit3 = p2_hit_r &&
           ($signed(pu) >= $signed(sx(cfg.u_low))) && ($signed(pu) <= $signed(sx(cfg.u_high))) &&
           ($signed(pv) >= $signed(sx(cfg.v_low))) && ($signed(pv) <= $signed(sx(cfg.v_high)));
  end

  logic          p3_v_r;
  rri_pkg::res_t p3_res_r;

  // P4: texture numerator and span; inside bounds both fit W bits unsigned
  logic [W-1:0]  pu_s, pv_s;
  rri_pkg::res_t res4;
  logic [W-1:0]  a_u, s_u, a_v, s_v;

  always_comb begin
    pu_s = (cfg.axis == rri_pkg::AXIS_YZ) ? p3_res_r.pz : p3_res_r.px;
    pv_s = (cfg.axis == rri_pkg::AXIS_XZ) ? p3_res_r.pz : p3_res_r.py;
    a_u  = pu_s - cfg.u_low;
    s_u  = cfg.u_high - cfg.u_low;
    a_v  = pv_s - cfg.v_low;
    s_v  = cfg.v_high - cfg.v_low;
    res4 = p3_res_r;
    // a zero span reads as 0/1 so the quotient comes out zero
    if (!p3_res_r.hit || s_u == '0) begin
      a_u = '0;
      s_u = {{(W-1){1'b0}}, 1'b1};
    end
    if (!p3_res_r.hit || s_v == '0) begin
      a_v = '0;
      s_v = {{(W-1){1'b0}}, 1'b1};
    end
    if (!p3_res_r.hit) res4 = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r    <= 1'b0;
      p2_v_r    <= 1'b0;
      p3_v_r    <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      p1_v_r    <= in_valid;
      p2_v_r    <= p1_v_r;
      p3_v_r    <= p2_v_r;
      out_valid <= p3_v_r;
    end
    if (en) begin
      p1_hit_r <= hit1;
      p1_t_r   <= t1;
      p1_ray_r <= in_ray;

      p2_hit_r <= p1_hit_r;
      p2_t_r   <= p1_t_r;
      p2_ray_r <= p1_ray_r;
      p2_px_r  <= (2*W)'($signed(p1_ray_r.dx) * $signed(p1_t_r));
      p2_py_r  <= (2*W)'($signed(p1_ray_r.dy) * $signed(p1_t_r));
      p2_pz_r  <= (2*W)'($signed(p1_ray_r.dz) * $signed(p1_t_r));

      p3_res_r.hit <= hit3;
      p3_res_r.t   <= p2_t_r;
      p3_res_r.px  <= sat(ptx);
      p3_res_r.py  <= sat(pty);
      p3_res_r.pz  <= sat(ptz);
      p3_res_r.ff  <= p2_ray_r.ff;

      out_res <= res4;
      out_a_u <= a_u;
      out_s_u <= s_u;
      out_a_v <= a_v;
      out_s_v <= s_v;
    end
  end

endmodule

/* sv/rri_texdiv.sv */
module rri_texdiv (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  rri_pkg::res_t             in_res,
  input  logic [rri_pkg::W-1:0]     in_a_u,
  input  logic [rri_pkg::W-1:0]     in_s_u,
  input  logic [rri_pkg::W-1:0]     in_a_v,
  input  logic [rri_pkg::W-1:0]     in_s_v,
  output logic                      out_valid,
  output rri_pkg::res_t             out_res,
  output logic [rri_pkg::TEX_W-1:0] out_tex_u,
  output logic [rri_pkg::TEX_W-1:0] out_tex_v
);

  localparam int W = rri_pkg::W;
  localparam int S = rri_pkg::TEX_W;

  // two lanes (u, v); quotient a*2^TEX_BITS/s with a <= s
  logic          v_r   [S];
  rri_pkg::res_t res_r [S];
  logic [W:0]    rem_r [S][2];
  logic [W-1:0]  dm_r  [S][2];
  logic [S-1:0]  q_r   [S][2];

  for (genvar k = 0; k < S; k++) begin : g_step
    logic          s_v;
    rri_pkg::res_t s_res;

    if (k == 0) begin : g_first
      assign s_v   = in_valid;
      assign s_res = in_res;
    end else begin : g_next
      assign s_v   = v_r[k-1];
      assign s_res = res_r[k-1];
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [W:0]   sh, rem_nxt;
      logic [W-1:0] s_dm;
      logic [S-1:0] s_q;
      logic         ge;

      if (k == 0) begin : g_first
        assign sh   = {1'b0, (l == 0) ? in_a_u : in_a_v};
        assign s_dm = (l == 0) ? in_s_u : in_s_v;
        assign s_q  = '0;
      end else begin : g_next
        assign sh   = {rem_r[k-1][l][W-1:0], 1'b0};
        assign s_dm = dm_r[k-1][l];
        assign s_q  = q_r[k-1][l];
      end

      always_comb begin
        ge      = sh >= {1'b0, s_dm};
        rem_nxt = ge ? (sh - {1'b0, s_dm}) : sh;
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k][l] <= rem_nxt;
          dm_r[k][l]  <= s_dm;
          q_r[k][l]   <= {s_q[S-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= s_v;
      end
      if (en) begin
        res_r[k] <= s_res;
      end
    end
  end

  assign out_valid = v_r[S-1];
  assign out_res   = res_r[S-1];
  assign out_tex_u = q_r[S-1][0];
  assign out_tex_v = q_r[S-1][1];

endmodule

/* sv/axis_rect_ray_intersect.sv */
// Pipeline: 1 prep register, 49 divider stages for t, 4 point stages and 17 texture
// divider stages; one request per cycle sustained while the output is not stalled.
// The pipeline advances as a whole; it holds while a result waits on out_tready.
// Reset (rst_n low at a clock edge, synchronous) clears all valid bits and loads
// the register defaults: xy plane, offset 0, bounds [0, 1.0] on u and v.
module axis_rect_ray_intersect (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_min, t_max
  input  logic [rri_pkg::IN_W-1:0]        in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // t_hit, point_x, point_y, point_z, tex_u, tex_v, front_face, zero pad
  output logic [rri_pkg::OUT_W-1:0]       out_tdata,
  // hit
  output logic                            out_tuser,
  input  logic                            cfg_we,
  input  logic [rri_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rri_pkg::W-1:0]           cfg_wdata
);

  localparam int W = rri_pkg::W;

  rri_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.axis   <= rri_pkg::AXIS_XY;
      cfg_r.offset <= '0;
      cfg_r.u_low  <= '0;
      cfg_r.u_high <= W'(1) << rri_pkg::FRAC_BITS;
      cfg_r.v_low  <= '0;
      cfg_r.v_high <= W'(1) << rri_pkg::FRAC_BITS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rri_pkg::CFG_AXIS:   cfg_r.axis   <= cfg_wdata[1:0];
        rri_pkg::CFG_OFFSET: cfg_r.offset <= cfg_wdata;
        rri_pkg::CFG_U_LOW:  cfg_r.u_low  <= cfg_wdata;
        rri_pkg::CFG_U_HIGH: cfg_r.u_high <= cfg_wdata;
        rri_pkg::CFG_V_LOW:  cfg_r.v_low  <= cfg_wdata;
        rri_pkg::CFG_V_HIGH: cfg_r.v_high <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  rri_pkg::ray_t in_ray;
  always_comb begin
    in_ray      = '0;
    in_ray.ox   = in_tdata[0*W +: W];
    in_ray.oy   = in_tdata[1*W +: W];
    in_ray.oz   = in_tdata[2*W +: W];
    in_ray.dx   = in_tdata[3*W +: W];
    in_ray.dy   = in_tdata[4*W +: W];
    in_ray.dz   = in_tdata[5*W +: W];
    in_ray.tmin = in_tdata[6*W +: W];
    in_ray.tmax = in_tdata[7*W +: W];
  end

  logic                      div_v;
  logic [rri_pkg::DIV_N-1:0] div_q;
  rri_pkg::ray_t             div_ray;

  rri_tdiv u_tdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_ray    (in_ray),
    .cfg       (cfg_r),
    .out_valid (div_v),
    .out_q     (div_q),
    .out_ray   (div_ray)
  );

  logic          pt_v;
  rri_pkg::res_t pt_res;
  logic [W-1:0]  a_u, s_u, a_v, s_v;

  rri_point u_point (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (div_v),
    .in_q      (div_q),
    .in_ray    (div_ray),
    .cfg       (cfg_r),
    .out_valid (pt_v),
    .out_res   (pt_res),
    .out_a_u   (a_u),
    .out_s_u   (s_u),
    .out_a_v   (a_v),
    .out_s_v   (s_v)
  );

  rri_pkg::res_t                fin_res;
  logic [rri_pkg::TEX_W-1:0]    tex_u, tex_v;

  rri_texdiv u_texdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (pt_v),
    .in_res    (pt_res),
    .in_a_u    (a_u),
    .in_s_u    (s_u),
    .in_a_v    (a_v),
    .in_s_v    (s_v),
    .out_valid (out_tvalid),
    .out_res   (fin_res),
    .out_tex_u (tex_u),
    .out_tex_v (tex_v)
  );

  assign out_tuser = fin_res.hit;
  assign out_tdata = {{(rri_pkg::OUT_W - rri_pkg::OUT_RAW_W){1'b0}},
                      fin_res.ff, tex_v, tex_u,
                      fin_res.pz, fin_res.py, fin_res.px, fin_res.t};

endmodule

/* sv/rri_checker.sv */
module rri_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [rri_pkg::OUT_W-1:0]  out_tdata,
  input logic                       out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("miss with nonzero fields");

  a_tex_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      out_tdata[144:128] <= 17'd65536 && out_tdata[161:145] <= 17'd65536)
    else $error("texture coordinate above 1.0");

endmodule

bind axis_rect_ray_intersect rri_checker u_rri_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
